// ===== hdl/nwg_pkg.sv =====
// Shared constants and control/status types for the necklace word generator.
`default_nettype none

package nwg_pkg;

  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 64;

  localparam logic [CFG_IDX_W-1:0] REG_WORD_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_SIZE = 2'd1;

  localparam logic [CFG_W-1:0] WORD_LENGTH_RST   = 5'd2;
  localparam logic [CFG_W-1:0] ALPHABET_SIZE_RST = 5'd2;

  typedef struct packed {
    logic clear;
    logic step;
    logic copy;
    logic load_out;
    logic exh;
  } nwg_cmd_t;

  typedef struct packed {
    logic pivot_found;
    logic pivot_last;
    logic copy_last;
    logic copy_div;
    logic final_word;
    logic out_free;
  } nwg_status_t;

endpackage

`default_nettype wire

// ===== hdl/nwg_if.sv =====
// Request and result channel interfaces of the necklace word generator.
`default_nettype none

interface nwg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface nwg_res_if;
  logic                      valid;
  logic                      ready;
  logic [nwg_pkg::OUT_W-1:0] necklace_word;
  logic                      is_final;
  logic                      exhausted;

  modport source (output valid, output necklace_word, output is_final, output exhausted,
                  input ready);
  modport sink (input valid, input necklace_word, input is_final, input exhausted,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/nwg_ctrl.sv =====
// Sequencer for request handling, FKM steps and result hand-off.
`default_nettype none

module nwg_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_restart,
  output logic                                in_ready,
  input  wire logic                           cfg_we,
  input  wire logic [nwg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire nwg_pkg::nwg_status_t           st,
  output nwg_pkg::nwg_cmd_t                   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_COPY   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   exh_r, exh_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    exh_nxt   = exh_r;
    cmd       = '0;
    cmd.exh   = exh_r;
    in_ready  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_restart || phase_r == PH_IDLE) begin
            cmd.clear = 1'b1;
            phase_nxt = PH_RUN;
            exh_nxt   = 1'b0;
            state_nxt = ST_EMIT;
          end else if (phase_r == PH_DONE) begin
            exh_nxt   = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (!st.pivot_found) begin
          phase_nxt = PH_DONE;
          exh_nxt   = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          cmd.step  = 1'b1;
          exh_nxt   = 1'b0;
          state_nxt = st.pivot_last ? ST_EMIT : ST_COPY;
        end
      end
      ST_COPY: begin
        cmd.copy = 1'b1;
        if (st.copy_last) begin
          state_nxt = st.copy_div ? ST_EMIT : ST_SEARCH;
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
          if (st.final_word && !exh_r) begin
            phase_nxt = PH_DONE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_we && (cfg_index == nwg_pkg::REG_WORD_LENGTH ||
                   cfg_index == nwg_pkg::REG_ALPHABET_SIZE)) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_IDLE;
      exh_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      exh_r   <= exh_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nwg_datapath.sv =====
// Word register file, pivot search, periodic copy and output register.
`default_nettype none

module nwg_datapath #(
  parameter int MAX_LENGTH  = 16,
  parameter int SYMBOL_BITS = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [nwg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nwg_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire nwg_pkg::nwg_cmd_t              cmd,
  output nwg_pkg::nwg_status_t                st,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic [nwg_pkg::OUT_W-1:0]           out_necklace_word,
  output logic                                out_is_final,
  output logic                                out_exhausted
);

  localparam int IDX_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int WIDE_W = MAX_LENGTH * SYMBOL_BITS;
  localparam int LW     = nwg_pkg::CFG_W;

  logic [LW-1:0]          word_length_r;
  logic [LW-1:0]          alphabet_size_r;
  logic [SYMBOL_BITS-1:0] word_r [MAX_LENGTH];
  logic [IDX_W-1:0]       piv_r;
  logic [IDX_W-1:0]       q_r;
  logic [IDX_W-1:0]       s_r;

  logic                      out_valid_r;
  logic [nwg_pkg::OUT_W-1:0] out_word_r;
  logic                      out_final_r;
  logic                      out_exh_r;

  logic [LW-1:0]          n_eff;
  logic [SYMBOL_BITS-1:0] sym_max;
  logic                   found;
  logic [IDX_W-1:0]       piv;
  logic                   all_max;
  logic [WIDE_W-1:0]      wide;
  logic                   out_free;

  always_comb begin
    if (word_length_r == '0) begin
      n_eff = LW'(1);
    end else if (word_length_r > LW'(MAX_LENGTH)) begin
      n_eff = LW'(MAX_LENGTH);
    end else begin
      n_eff = word_length_r;
    end
    if (alphabet_size_r < LW'(2)) begin
      sym_max = SYMBOL_BITS'(1);
    end else if (32'(alphabet_size_r) > (32'd1 << SYMBOL_BITS)) begin
      sym_max = '1;
    end else begin
      sym_max = SYMBOL_BITS'(alphabet_size_r - LW'(1));
    end
  end

  always_comb begin
    found   = 1'b0;
    piv     = '0;
    all_max = 1'b1;
    wide    = '0;
    for (int p = 0; p < MAX_LENGTH; p++) begin
      if (LW'(p) < n_eff) begin
        wide[p*SYMBOL_BITS +: SYMBOL_BITS] = word_r[p];
        if (word_r[p] != sym_max) begin
          found   = 1'b1;
          piv     = IDX_W'(p);
          all_max = 1'b0;
        end
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    st             = '0;
    st.pivot_found = found;
    st.pivot_last  = (LW'(piv) + LW'(1)) == n_eff;
    st.copy_last   = (LW'(q_r) + LW'(1)) == n_eff;
    st.copy_div    = (s_r == piv_r);
    st.final_word  = all_max;
    st.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_length_r   <= nwg_pkg::WORD_LENGTH_RST;
      alphabet_size_r <= nwg_pkg::ALPHABET_SIZE_RST;
    end else if (cfg_we) begin
      if (cfg_index == nwg_pkg::REG_WORD_LENGTH) begin
        word_length_r <= cfg_wdata;
      end else if (cfg_index == nwg_pkg::REG_ALPHABET_SIZE) begin
        alphabet_size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      for (int p = 0; p < MAX_LENGTH; p++) begin
        word_r[p] <= '0;
      end
    end else if (cmd.step) begin
      word_r[piv] <= word_r[piv] + SYMBOL_BITS'(1);
      piv_r       <= piv;
      q_r         <= IDX_W'(LW'(piv) + LW'(1));
      s_r         <= '0;
    end else if (cmd.copy) begin
      word_r[q_r] <= word_r[s_r];
      q_r         <= q_r + IDX_W'(1);
      s_r         <= (s_r == piv_r) ? '0 : s_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r  <= cmd.exh ? '0 : nwg_pkg::OUT_W'(wide);
      out_final_r <= !cmd.exh && all_max;
      out_exh_r   <= cmd.exh;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_necklace_word = out_word_r;
  assign out_is_final      = out_final_r;
  assign out_exhausted     = out_exh_r;

endmodule

`default_nettype wire

// ===== hdl/necklace_word_generator_unit.sv =====
// Top level: necklace word generator with request/result channels and config port.
// A restart or exhausted result is registered from the emit state once the output is free.
// A next-necklace request runs FKM steps until a word is emitted or no pivot is left; a step
// is a pivot search and, unless the pivot is the last symbol, a one-symbol-per-cycle copy.
// One request is in flight at a time; a full output register holds the next result back.
// Reset (rst_n low, synchronous): config back to length 2 / alphabet 2, sequence unstarted.
`default_nettype none

module necklace_word_generator_unit #(
  parameter int MAX_LENGTH  = 16,
  parameter int SYMBOL_BITS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  nwg_req_if.sink                            in_chan,
  nwg_res_if.source                          out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [nwg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nwg_pkg::CFG_W-1:0]     cfg_wdata
);

  nwg_pkg::nwg_cmd_t    cmd;
  nwg_pkg::nwg_status_t st;

  nwg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_restart (in_chan.restart),
    .in_ready   (in_chan.ready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .st         (st),
    .cmd        (cmd)
  );

  nwg_datapath #(
    .MAX_LENGTH  (MAX_LENGTH),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .st                (st),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_necklace_word (out_chan.necklace_word),
    .out_is_final      (out_chan.is_final),
    .out_exhausted     (out_chan.exhausted)
  );

endmodule

`default_nettype wire

// ===== hdl/nwg_checker.sv =====
// Port-level checks for the necklace word generator and their bind.
`default_nettype none

module nwg_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [nwg_pkg::OUT_W-1:0] out_necklace_word,
  input wire logic                      out_is_final,
  input wire logic                      out_exhausted
);

  a_exh_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exhausted |-> out_necklace_word == '0 && !out_is_final)
    else $error("exhausted result carries a word or final flag");

  a_final_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_final |-> out_necklace_word != '0)
    else $error("final word is zero");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_necklace_word) &&
      $stable(out_is_final) && $stable(out_exhausted))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind necklace_word_generator_unit nwg_checker u_nwg_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_necklace_word (out_chan.necklace_word),
  .out_is_final      (out_chan.is_final),
  .out_exhausted     (out_chan.exhausted)
);

`default_nettype wire
